FILE: rtl/air_quality_index_estimator_assert.svh
// Assertion macros for the air quality index estimator
`ifndef AIR_QUALITY_INDEX_ESTIMATOR_ASSERT_SVH
`define AIR_QUALITY_INDEX_ESTIMATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AQI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define AQI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/aqi_pkg.sv
// Shared constants, types and control structs of the air quality index estimator
package aqi_pkg;

  localparam int FRAC_BITS  = 16;               // baseline fraction bits
  localparam int GAS_W      = 24;
  localparam int HUM_W      = 17;
  localparam int BASE_W     = GAS_W + FRAC_BITS; // baseline width
  localparam int MUL_B_W    = 17;               // serial multiplier operand width
  localparam int PROD_W     = BASE_W + MUL_B_W;
  localparam int Q_W        = 14;               // quotient bits, 80*127 < 2**14
  localparam int CNT_W      = $clog2(MUL_B_W);
  localparam int ALPHA_FRAC = 16;
  localparam int WGT_W      = 7;
  localparam int IAQ_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic [MUL_B_W-1:0] ALPHA_ONE = MUL_B_W'(65536);
  localparam logic [IAQ_W-1:0]   IAQ_MAX   = IAQ_W'(8000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_TARGET = 3'd0,
    REG_HUM_SPAN   = 3'd1,
    REG_HUM_WEIGHT = 3'd2,
    REG_GAS_WEIGHT = 3'd3,
    REG_ALPHA      = 3'd4
  } aqi_reg_t;

  typedef struct packed {
    logic                mul_go;
    logic                div_go;
    logic [BASE_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [BASE_W-1:0]   divisor;
  } aqi_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aqi_stat_t;

endpackage

FILE: rtl/aqi_muldiv.sv
// Bit-serial shift-add multiplier and restoring divider; the divider takes its dividend from the product register
module aqi_muldiv import aqi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  aqi_cmd_t          cmd,
  output aqi_stat_t         stat,
  output logic [PROD_W-1:0] product,
  output logic [Q_W-1:0]    quotient
);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_MUL  = 3'b010,
    U_DIV  = 3'b100
  } unit_state_t;

  unit_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [BASE_W-1:0]   a_r, a_nxt;
  logic [BASE_W-1:0]   div_r, div_nxt;
  logic [BASE_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]      quo_r, quo_nxt;
  logic [BASE_W:0]     sum;
  logic [BASE_W:0]     trial;
  logic                qbit;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    a_nxt     = a_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    sum       = {1'b0, prod_r[PROD_W-1:MUL_B_W]} + (prod_r[0] ? {1'b0, a_r} : '0);
    trial     = {rem_r, quo_r[Q_W-1]};
    qbit      = trial >= {1'b0, div_r};
    unique case (state_r)
      U_IDLE: begin
        cnt_nxt = '0;
        if (cmd.mul_go) begin
          prod_nxt  = {{BASE_W{1'b0}}, cmd.mul_b};
          a_nxt     = cmd.mul_a;
          state_nxt = U_MUL;
        end else if (cmd.div_go) begin
          // quotient is known to fit Q_W bits, so the upper part starts below the divisor
          rem_nxt   = prod_r[Q_W+BASE_W-1:Q_W];
          quo_nxt   = prod_r[Q_W-1:0];
          div_nxt   = cmd.divisor;
          state_nxt = U_DIV;
        end
      end
      U_MUL: begin
        prod_nxt = {sum, prod_r[MUL_B_W-1:1]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_B_W-1)) begin
          state_nxt = U_IDLE;
          done_nxt  = 1'b1;
        end
      end
      U_DIV: begin
        rem_nxt = qbit ? BASE_W'(trial - {1'b0, div_r}) : trial[BASE_W-1:0];
        quo_nxt = {quo_r[Q_W-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W-1)) begin
          state_nxt = U_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign stat.busy = (state_r != U_IDLE);
  assign stat.done = done_r;
  assign product   = prod_r;
  assign quotient  = quo_r;

endmodule

FILE: rtl/air_quality_index_estimator.sv
// Top level of the air quality index estimator: control sequencer, registers, stream ports
//
// One input item carries a humidity sample and a gas resistance; each gives exactly
// one result item with the air quality index (1/16 units, 0..8000) and the integer
// part of the updated gas baseline.
// The first item after reset loads the baseline; later items move it by
// alpha*(gas - baseline) in Q16, toward the gas reading.
// All arithmetic runs on one bit-serial unit: a 17-step shift-add multiply and a
// 14-step restoring divide. An item takes one baseline multiply, then a multiply and
// divide for the humidity score and for the gas score; the first item skips the
// baseline multiply, and a zero baseline skips the gas multiply and divide. One item
// is in work at a time. in_tready is high only while the sequencer is idle; a finished
// result sits in the output register, so the next item is taken while out_tvalid waits
// on out_tready. A stalled receiver holds the result, and the sequencer waits at its
// last step until the output register is free. Reset (rst_n low, synchronous) clears
// the baseline, the result valid and restores the register defaults. The user must see
// that registers are written through cfg_* only while the block is idle; the block
// itself does not enforce this.
`include "air_quality_index_estimator_assert.svh"

module air_quality_index_estimator import aqi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // humidity_sample[16:0], gas_ohms[40:17], zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // iaq_index[12:0], baseline_ohms[36:13], zero
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_BASE_GO = 10'b00_0000_0010,
    S_BASE_WT = 10'b00_0000_0100,
    S_HUM_GO  = 10'b00_0000_1000,
    S_HUM_MWT = 10'b00_0001_0000,
    S_HUM_DWT = 10'b00_0010_0000,
    S_GAS_GO  = 10'b00_0100_0000,
    S_GAS_MWT = 10'b00_1000_0000,
    S_GAS_DWT = 10'b01_0000_0000,
    S_FIN     = 10'b10_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 loaded_r, loaded_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [HUM_W-1:0]     hum_r, hum_nxt;
  logic [GAS_W-1:0]     gas_r, gas_nxt;
  logic [Q_W-1:0]       hum_term_r, hum_term_nxt;
  logic [Q_W-1:0]       gas_term_r, gas_term_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IAQ_W-1:0]     out_iaq_r, out_iaq_nxt;
  logic [GAS_W-1:0]     out_base_r, out_base_nxt;

  logic [HUM_W-1:0]     target_r, span_r, alpha_r;
  logic [WGT_W-1:0]     hum_wgt_r, gas_wgt_r;

  aqi_cmd_t             cmd;
  aqi_stat_t            stat;
  logic [PROD_W-1:0]    product;
  logic [Q_W-1:0]       quotient;

  logic [BASE_W-1:0]    gas_tgt, mag, gas_s, step;
  logic                 up;
  logic [MUL_B_W-1:0]   alpha_eff;
  logic [HUM_W-1:0]     span_eff, dev, dev_c;
  logic [Q_W-1:0]       hum_w80, gas_w80;
  logic [Q_W:0]         total;
  logic [IAQ_W-1:0]     iaq;

  aqi_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .product  (product),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= HUM_W'(40960);
      span_r    <= HUM_W'(20480);
      hum_wgt_r <= WGT_W'(25);
      gas_wgt_r <= WGT_W'(75);
      alpha_r   <= MUL_B_W'(655);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HUM_TARGET: target_r  <= cfg_wdata;
        REG_HUM_SPAN:   span_r    <= cfg_wdata;
        REG_HUM_WEIGHT: hum_wgt_r <= cfg_wdata[WGT_W-1:0];
        REG_GAS_WEIGHT: gas_wgt_r <= cfg_wdata[WGT_W-1:0];
        REG_ALPHA:      alpha_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    gas_tgt   = BASE_W'(gas_r) << FRAC_BITS;
    up        = gas_tgt >= base_r;
    mag       = up ? gas_tgt - base_r : base_r - gas_tgt;
    step      = product[ALPHA_FRAC+BASE_W-1:ALPHA_FRAC];
    alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    span_eff  = (span_r == '0) ? HUM_W'(1) : span_r;
    dev       = (hum_r >= target_r) ? hum_r - target_r : target_r - hum_r;
    dev_c     = (dev > span_eff) ? span_eff : dev;
    gas_s     = (gas_tgt > base_r) ? base_r : gas_tgt;
    // weight * 80 as weight*64 + weight*16
    hum_w80   = Q_W'({hum_wgt_r, 6'b0}) + Q_W'({hum_wgt_r, 4'b0});
    gas_w80   = Q_W'({gas_wgt_r, 6'b0}) + Q_W'({gas_wgt_r, 4'b0});
    total     = {1'b0, hum_term_r} + {1'b0, gas_term_r};
    iaq       = (total > (Q_W+1)'(IAQ_MAX)) ? IAQ_MAX : total[IAQ_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    base_nxt      = base_r;
    hum_nxt       = hum_r;
    gas_nxt       = gas_r;
    hum_term_nxt  = hum_term_r;
    gas_term_nxt  = gas_term_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_iaq_nxt   = out_iaq_r;
    out_base_nxt  = out_base_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          hum_nxt   = in_tdata[HUM_W-1:0];
          gas_nxt   = in_tdata[HUM_W+GAS_W-1:HUM_W];
          state_nxt = S_BASE_GO;
        end
      end
      S_BASE_GO: begin
        if (loaded_r) begin
          cmd.mul_go = 1'b1;
          cmd.mul_a  = mag;
          cmd.mul_b  = alpha_eff;
          state_nxt  = S_BASE_WT;
        end else begin
          base_nxt   = gas_tgt;
          loaded_nxt = 1'b1;
          state_nxt  = S_HUM_GO;
        end
      end
      S_BASE_WT: begin
        if (stat.done) begin
          base_nxt  = up ? base_r + step : base_r - step;
          state_nxt = S_HUM_GO;
        end
      end
      S_HUM_GO: begin
        cmd.mul_go = 1'b1;
        cmd.mul_a  = BASE_W'(span_eff - dev_c);
        cmd.mul_b  = MUL_B_W'(hum_w80);
        state_nxt  = S_HUM_MWT;
      end
      S_HUM_MWT: begin
        if (stat.done) begin
          cmd.div_go  = 1'b1;
          cmd.divisor = BASE_W'(span_eff);
          state_nxt   = S_HUM_DWT;
        end
      end
      S_HUM_DWT: begin
        if (stat.done) begin
          hum_term_nxt = quotient;
          state_nxt    = S_GAS_GO;
        end
      end
      S_GAS_GO: begin
        if (base_r == '0) begin
          gas_term_nxt = '0;
          state_nxt    = S_FIN;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mul_a  = gas_s;
          cmd.mul_b  = MUL_B_W'(gas_w80);
          state_nxt  = S_GAS_MWT;
        end
      end
      S_GAS_MWT: begin
        if (stat.done) begin
          cmd.div_go  = 1'b1;
          cmd.divisor = base_r;
          state_nxt   = S_GAS_DWT;
        end
      end
      S_GAS_DWT: begin
        if (stat.done) begin
          gas_term_nxt = quotient;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_iaq_nxt   = iaq;
          out_base_nxt  = base_r[BASE_W-1:FRAC_BITS];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= 1'b0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hum_r      <= hum_nxt;
    gas_r      <= gas_nxt;
    hum_term_r <= hum_term_nxt;
    gas_term_r <= gas_term_nxt;
    out_iaq_r  <= out_iaq_nxt;
    out_base_r <= out_base_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-IAQ_W-GAS_W){1'b0}}, out_base_r, out_iaq_r};

  `AQI_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_tvalid && in_tready, !in_tready,
                  "sequencer did not leave idle after accepting an item")
  `AQI_ASSERT_IMP(a_idle_unit_free, clk, rst_n, state_r == S_IDLE, !stat.busy,
                  "arithmetic unit busy while sequencer idle")
  `AQI_ASSERT_IMP(a_iaq_saturated, clk, rst_n, out_valid_r, out_iaq_r <= IAQ_MAX,
                  "index above saturation limit")
  `AQI_ASSERT_NXT(a_baseline_stays, clk, rst_n, loaded_r, loaded_r,
                  "baseline loaded flag dropped without reset")

endmodule

FILE: test/aqi_index_checker.sv
// Checker for the air quality index estimator: predicts each result and compares it
module aqi_index_checker import aqi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // humidity_sample, gas_ohms, zero
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // iaq_index, baseline_ohms, zero
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IAQ_W-1:0] iaq;
    logic [GAS_W-1:0] base;
  } score_t;

  // points * 5 * 16
  localparam logic [63:0] POINT_SCALE = 64'd80;
  localparam int          MAX_REPORTS = 10;

  localparam logic [HUM_W-1:0]   TARGET_RST = HUM_W'(40960);
  localparam logic [HUM_W-1:0]   SPAN_RST   = HUM_W'(20480);
  localparam logic [WGT_W-1:0]   HUM_WT_RST = WGT_W'(25);
  localparam logic [WGT_W-1:0]   GAS_WT_RST = WGT_W'(75);
  localparam logic [MUL_B_W-1:0] ALPHA_RST  = MUL_B_W'(655);

  logic [HUM_W-1:0]   hum_target;
  logic [HUM_W-1:0]   hum_span;
  logic [WGT_W-1:0]   hum_weight;
  logic [WGT_W-1:0]   gas_weight;
  logic [MUL_B_W-1:0] alpha;
  logic               loaded;
  logic [BASE_W-1:0]  baseline;

  score_t expected_scores[$];
  int     fails = 0;

  function automatic score_t predict_score(logic [HUM_W-1:0] hum, logic [GAS_W-1:0] gas);
    logic [63:0] target;
    logic [63:0] step;
    logic [63:0] a;
    logic [63:0] span;
    logic [63:0] dev;
    logic [63:0] hum_pts;
    logic [63:0] gas_pts;
    logic [63:0] total;
    score_t      r;
    target = 64'(gas) << FRAC_BITS;
    a = (alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha);
    if (!loaded) begin
      baseline = BASE_W'(target);
      loaded   = 1'b1;
    end else if (target >= 64'(baseline)) begin
      step     = ((target - 64'(baseline)) * a) >> ALPHA_FRAC;
      baseline = BASE_W'(64'(baseline) + step);
    end else begin
      step     = ((64'(baseline) - target) * a) >> ALPHA_FRAC;
      baseline = BASE_W'(64'(baseline) - step);
    end
    span = (hum_span == '0) ? 64'd1 : 64'(hum_span);
    dev  = (hum >= hum_target) ? 64'(hum) - 64'(hum_target) : 64'(hum_target) - 64'(hum);
    if (dev > span) dev = span;
    hum_pts = (POINT_SCALE * 64'(hum_weight) * (span - dev)) / span;
    if (baseline == '0) begin
      gas_pts = '0;
    end else begin
      gas_pts = (POINT_SCALE * 64'(gas_weight) *
                 ((target > 64'(baseline)) ? 64'(baseline) : target)) / 64'(baseline);
    end
    total = hum_pts + gas_pts;
    if (total > 64'(IAQ_MAX)) total = 64'(IAQ_MAX);
    r.iaq  = IAQ_W'(total);
    r.base = baseline[FRAC_BITS +: GAS_W];
    return r;
  endfunction

  always @(posedge clk) begin
    score_t got;
    score_t want;
    if (!rst_n) begin
      hum_target = TARGET_RST;
      hum_span   = SPAN_RST;
      hum_weight = HUM_WT_RST;
      gas_weight = GAS_WT_RST;
      alpha      = ALPHA_RST;
      loaded     = 1'b0;
      baseline   = '0;
      expected_scores.delete();
    end else begin
      if (cfg_wr_en) begin
        case (aqi_reg_t'(cfg_index))
          REG_HUM_TARGET: hum_target = cfg_wdata[HUM_W-1:0];
          REG_HUM_SPAN:   hum_span   = cfg_wdata[HUM_W-1:0];
          REG_HUM_WEIGHT: hum_weight = cfg_wdata[WGT_W-1:0];
          REG_GAS_WEIGHT: gas_weight = cfg_wdata[WGT_W-1:0];
          REG_ALPHA:      alpha      = cfg_wdata[MUL_B_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.iaq  = out_tdata[IAQ_W-1:0];
        got.base = out_tdata[IAQ_W +: GAS_W];
        if (expected_scores.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("unexpected result: iaq %0d baseline %0d", got.iaq, got.base);
        end else begin
          want = expected_scores.pop_front();
          if (got.iaq !== want.iaq || got.base !== want.base) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("mismatch: iaq exp %0d got %0d, baseline exp %0d got %0d",
                       want.iaq, got.iaq, want.base, got.base);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_scores.push_back(predict_score(in_tdata[HUM_W-1:0], in_tdata[HUM_W +: GAS_W]));
    end
    pending    <= expected_scores.size();
    fail_count <= fails;
  end

endmodule

FILE: test/tb_top.sv
// Testbench top of the air quality index estimator: clock, reset, stimulus and verdict
module tb_top import aqi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES    = 9;
  localparam int MAX_GAP         = 13;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_AT         = 500;
  localparam int LONG_HOLD       = 400;
  localparam int IDLE_LIMIT      = 3000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 200;

  localparam logic [HUM_W-1:0]      HUM_MAX  = HUM_W'(102400);
  localparam logic [HUM_W-1:0]      HUM_FULL = '1;
  localparam logic [GAS_W-1:0]      GAS_MAX  = '1;
  localparam logic [CFG_DATA_W-1:0] CFG_FULL = '1;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_FIRST = CFG_IDX_W'(5);

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  int               tx_max_gap = MAX_GAP;
  int               rx_max_gap = MAX_GAP;
  logic [HUM_W-1:0] sh_target  = HUM_W'(40960);
  logic [HUM_W-1:0] sh_span    = HUM_W'(20480);
  logic [GAS_W-1:0] gas_level  = GAS_W'(100000);

  air_quality_index_estimator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  aqi_index_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_item(input logic [HUM_W-1:0] hum, input logic [GAS_W-1:0] gas);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({gas, hum});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HUM_TARGET: sh_target = val[HUM_W-1:0];
      REG_HUM_SPAN:   sh_span   = val[HUM_W-1:0];
      default: ;
    endcase
  endtask

  // block must be idle; junk writes go to unmapped indexes
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] target, input logic [CFG_DATA_W-1:0] span,
                               input logic [CFG_DATA_W-1:0] hum_wt, input logic [CFG_DATA_W-1:0] gas_wt,
                               input logic [CFG_DATA_W-1:0] alpha, input int junk);
    drain();
    write_reg(REG_HUM_TARGET, target);
    write_reg(REG_HUM_SPAN, span);
    write_reg(REG_HUM_WEIGHT, hum_wt);
    write_reg(REG_GAS_WEIGHT, gas_wt);
    write_reg(REG_ALPHA, alpha);
    for (int j = 0; j < junk; j++)
      write_reg(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_setting();
    logic [CFG_DATA_W-1:0] t;
    logic [CFG_DATA_W-1:0] s;
    logic [CFG_DATA_W-1:0] hw;
    logic [CFG_DATA_W-1:0] gw;
    logic [CFG_DATA_W-1:0] a;
    case ($urandom_range(0, 5))
      0: t = '0;
      1: t = HUM_MAX;
      2: t = CFG_DATA_W'($urandom_range(0, CFG_FULL));
      default: t = CFG_DATA_W'($urandom_range(0, HUM_MAX));
    endcase
    case ($urandom_range(0, 7))
      0: s = '0;
      1: s = CFG_DATA_W'(1);
      2: s = CFG_DATA_W'($urandom_range(1, 64));
      3: s = HUM_MAX;
      4: s = CFG_FULL;
      default: s = CFG_DATA_W'($urandom_range(1, HUM_MAX));
    endcase
    case ($urandom_range(0, 5))
      0: hw = '0;
      1: hw = CFG_DATA_W'(100);
      2: hw = CFG_DATA_W'(127);
      default: hw = CFG_DATA_W'($urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 5))
      0: gw = '0;
      1: gw = CFG_DATA_W'(100);
      2: gw = CFG_DATA_W'(127);
      default: gw = CFG_DATA_W'($urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 7))
      0: a = '0;
      1: a = ALPHA_ONE;
      2: a = CFG_DATA_W'($urandom_range(ALPHA_ONE + 1, CFG_FULL));
      3: a = CFG_DATA_W'($urandom_range(1, 64));
      4: a = CFG_DATA_W'(655);
      default: a = CFG_DATA_W'($urandom_range(0, ALPHA_ONE));
    endcase
    apply_setting(t, s, hw, gw, a, $urandom_range(0, 1));
  endtask

  function automatic logic [HUM_W-1:0] pick_humidity();
    int lo;
    int hi;
    lo = int'(sh_target) - int'(sh_span) - 64;
    hi = int'(sh_target) + int'(sh_span) + 64;
    if (lo < 0) lo = 0;
    if (hi > int'(HUM_FULL)) hi = int'(HUM_FULL);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return HUM_MAX;
      2: return HUM_W'($urandom_range(0, HUM_FULL));
      3, 4, 5: return HUM_W'($urandom_range(lo, hi));
      default: return HUM_W'($urandom_range(0, HUM_MAX));
    endcase
  endfunction

  function automatic logic [GAS_W-1:0] pick_gas();
    int spread;
    int v;
    spread = int'(gas_level) / 4 + 16;
    v = int'(gas_level) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(GAS_MAX)) v = int'(GAS_MAX);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return GAS_MAX;
      2: return GAS_W'($urandom);
      3: return GAS_W'($urandom_range(0, 255));
      default: return GAS_W'(v);
    endcase
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return MAX_GAP;
    endcase
  endfunction

  // result side
  initial begin
    int gap;
    int taken;
    out_tready = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      gap = (taken == HOLD_AT) ? LONG_HOLD : $urandom_range(0, rx_max_gap);
      if (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults; first item loads a zero baseline
    send_item(HUM_W'(40960), '0);
    send_item('0, '0);
    send_item(HUM_MAX, GAS_MAX);
    send_item(HUM_W'(61440), GAS_W'(1));
    send_item(HUM_FULL, GAS_MAX);
    send_item(HUM_W'(40960), GAS_W'(24'h800000));
    send_item(HUM_W'(20480), GAS_W'(12345));

    // zero span, weights past one hundred, alpha exactly one
    apply_setting(HUM_MAX, '0, CFG_DATA_W'(127), CFG_DATA_W'(127), ALPHA_ONE, 0);
    send_item(HUM_MAX, GAS_W'(1000));
    send_item(HUM_MAX, GAS_W'(1000));
    send_item(HUM_W'(HUM_MAX - 1), GAS_W'(1000));
    send_item(HUM_FULL, '0);
    send_item(HUM_MAX, GAS_W'(5));
    send_item('0, GAS_MAX);

    // alpha above one, unmapped register writes
    apply_setting('0, CFG_FULL, '0, CFG_DATA_W'(100), CFG_FULL, 3);
    send_item('0, GAS_W'(777));
    send_item(HUM_FULL, GAS_W'(1));
    send_item(HUM_W'(65536), GAS_W'(65535));

    // frozen baseline
    apply_setting(CFG_DATA_W'(40960), CFG_DATA_W'(1), CFG_DATA_W'(100), '0, '0, 0);
    send_item(HUM_W'(40960), '0);
    send_item(HUM_W'(40961), GAS_MAX);
    send_item(HUM_W'(40959), GAS_W'(100));

    apply_setting(CFG_DATA_W'(40960), CFG_DATA_W'(20480), CFG_DATA_W'(25), CFG_DATA_W'(75),
                  CFG_DATA_W'(655), 0);
    send_item(HUM_W'(45000), GAS_W'(200000));
    send_item(HUM_W'(30000), GAS_W'(150000));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_setting();
      gas_level = ($urandom_range(0, 3) == 0) ? GAS_W'($urandom_range(0, 4096)) : GAS_W'($urandom);
      if (p == 1) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else begin
        tx_max_gap = pick_gap_max();
        rx_max_gap = pick_gap_max();
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == ITEMS_PER_PHASE / 2) drain();
        if (n % 32 == 31) gas_level = GAS_W'($urandom);
        send_item(pick_humidity(), pick_gas());
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
